// ===== hw/rtl/asw_pkg.sv =====
`default_nettype none

package asw_pkg;

  // field widths
  localparam int RAW_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int FACTOR_W = 17;
  localparam int VAL_W    = 20;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 2'd2;

  // register reset values
  localparam logic [RAW_W-1:0]    OFFSET_RESET = 16'd0;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd1004544;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd6554;

  // unity weight in q1.16
  localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = 20'sd524287;
  localparam val_t VAL_MIN = -20'sd524288;

  // clamp a 26-bit intermediate to the value range
  function automatic val_t sat_val(input logic signed [25:0] v);
    if (v > 26'sd524287) begin
      return VAL_MAX;
    end else if (v < -26'sd524288) begin
      return VAL_MIN;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asw_ram.sv =====
`default_nettype none

module asw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/accel_smoothing_window_average_top.sv =====
`default_nettype none
// a result beat is loaded at the end of the sum step, which waits while the result register is busy
// the single sequencer takes one item at a time (in_stall stays high until it is idle) and runs
//   two dependent multiplies with their rounding stages and the window ram write-back
// reset (rst, synchronous): registers to their defaults, window empty (reads as zero
//   until the write pointer has gone round once), smoothed value and sum cleared

module accel_smoothing_window_average_top #(
  parameter int WINDOW_LENGTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // sample channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [asw_pkg::RAW_W-1:0]      raw_sample,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [asw_pkg::VAL_W-1:0]     smoothed_accel,
  output logic signed [asw_pkg::VAL_W-1:0]     average_accel,
  // register write port
  input  wire                                  cfg_wr_en,
  input  wire [asw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [asw_pkg::CFG_W-1:0]             cfg_data
);

  import asw_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = VAL_W + POS_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL1   = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;
  localparam logic [2:0] S_SMOOTH = 3'd6;
  localparam logic [2:0] S_SUM    = 3'd7;

  logic [2:0] state;

  // configuration registers
  logic signed [RAW_W-1:0] zero_offset;
  logic [GAIN_W-1:0]       count_gain;
  logic [FACTOR_W-1:0]     smoothing_factor;

  // persistent state
  val_t                    smoothed_value;
  logic [POS_W-1:0]        write_position;
  logic                    full;
  logic signed [SUM_W-1:0] window_sum;

  // per-item working registers
  logic signed [RAW_W:0]   delta;
  logic signed [41:0]      gain_prod;
  val_t                    old_entry;
  val_t                    accel;
  logic signed [VAL_W:0]   diff;
  logic signed [38:0]      step_prod;
  logic signed [22:0]      step;
  val_t                    smoothed;

  // window ram
  logic                    ram_we;
  logic [VAL_W-1:0]        ram_rdata;

  logic in_acc;
  logic out_free;
  logic sum_go;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // the last step only runs once the result register can take the beat
  assign sum_go   = (state == S_SUM) && out_free;
  assign ram_we   = sum_go;

  asw_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_position),
    .wdata (smoothed),
    .raddr (write_position),
    .rdata (ram_rdata)
  );

  // combinational pieces of the stages
  logic signed [41:0]      gain_round;
  logic signed [38:0]      step_round;
  logic signed [23:0]      smooth_wide;
  logic [FACTOR_W-1:0]     factor_lim;
  logic signed [SUM_W-1:0] window_sum_next;

  always_comb begin
    gain_round  = gain_prod + 42'sd32768;
    step_round  = step_prod + 39'sd32768;
    smooth_wide = {{4{smoothed_value[VAL_W-1]}}, smoothed_value} + {step[22], step};
    // weights above one behave as one
    factor_lim  = (smoothing_factor > ONE_Q16) ? ONE_Q16 : smoothing_factor;
    window_sum_next = window_sum
                    + SUM_W'(smoothed)
                    - SUM_W'(old_entry);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset      <= OFFSET_RESET;
      count_gain       <= GAIN_RESET;
      smoothing_factor <= FACTOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ZERO_OFFSET:      zero_offset      <= cfg_data[RAW_W-1:0];
        REG_COUNT_GAIN:       count_gain       <= cfg_data[GAIN_W-1:0];
        REG_SMOOTHING_FACTOR: smoothing_factor <= cfg_data[FACTOR_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      smoothed_value <= '0;
      write_position <= '0;
      full           <= 1'b0;
      window_sum     <= '0;
      out_valid      <= 1'b0;
    end else begin
      // a beat taken in the same cycle as a new one is loaded keeps valid high
      if (out_valid && !out_stall && !sum_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_MUL1;
          end
        end
        S_MUL1:   state <= S_ACC;
        S_ACC:    state <= S_DIFF;
        S_DIFF:   state <= S_MUL2;
        S_MUL2:   state <= S_STEP;
        S_STEP:   state <= S_SMOOTH;
        S_SMOOTH: state <= S_SUM;
        S_SUM: begin
          if (sum_go) begin
            state          <= S_IDLE;
            smoothed_value <= smoothed;
            window_sum     <= window_sum_next;
            write_position <= write_position + 1'b1;
            if (write_position == POS_LAST) begin
              full <= 1'b1;
            end
            out_valid      <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      delta <= {raw_sample[RAW_W-1], raw_sample} - {zero_offset[RAW_W-1], zero_offset};
    end
    case (state)
      S_MUL1: begin
        gain_prod <= 42'(delta * $signed({1'b0, count_gain}));
        // entry not yet written since reset reads as zero
        old_entry <= full ? val_t'(ram_rdata) : '0;
      end
      S_ACC:    accel <= sat_val(gain_round[41:16]);
      S_DIFF:   diff  <= {accel[VAL_W-1], accel} - {smoothed_value[VAL_W-1], smoothed_value};
      S_MUL2:   step_prod <= 39'($signed({1'b0, factor_lim}) * diff);
      S_STEP:   step  <= step_round[38:16];
      S_SMOOTH: smoothed <= sat_val({{2{smooth_wide[23]}}, smooth_wide});
      S_SUM: begin
        if (sum_go) begin
          smoothed_accel <= smoothed;
          // mean over a power-of-two window is an arithmetic shift
          average_accel  <= window_sum_next[SUM_W-1:POS_W];
        end
      end
      default: ;
    endcase
  end

  // checks
  a_old_zero_until_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && !full) |-> (old_entry == '0))
    else $error("window entry not read as zero before first wrap");

  a_full_on_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> (write_position == '0) && ($past(write_position) == POS_LAST))
    else $error("window marked full away from the wrap");

  a_result_after_sum: assert property (@(posedge clk) disable iff (rst)
    sum_go |=> out_valid && (state == S_IDLE) && (smoothed_accel == smoothed_value))
    else $error("result beat not loaded at end of item");

  a_sum_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && !out_free) |=> (state == S_SUM) && $stable(window_sum))
    else $error("window sum moved while result register busy");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN         = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BLOCKS      = 9;
  localparam int BLOCK_ITEMS = 150;

  // index with no register behind it, writes must be dropped
  localparam logic [asw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    asw_pkg::val_t smoothed;
    asw_pkg::val_t mean;
  } accel_result_t;

  // predicts smoothed value and window mean for every accepted sample beat
  class window_average_scoreboard;
    logic signed [asw_pkg::RAW_W-1:0]    zero_offset;
    logic        [asw_pkg::GAIN_W-1:0]   count_gain;
    logic        [asw_pkg::FACTOR_W-1:0] smoothing_factor;
    asw_pkg::val_t smoothed_now;
    asw_pkg::val_t window[WIN];
    int unsigned   slot;
    longint        window_total;
    accel_result_t awaited_accel[$];
    int            failures;

    function new();
      zero_offset      = asw_pkg::OFFSET_RESET;
      count_gain       = asw_pkg::GAIN_RESET;
      smoothing_factor = asw_pkg::FACTOR_RESET;
      smoothed_now     = '0;
      foreach (window[i]) window[i] = '0;
      slot         = 0;
      window_total = 0;
      failures     = 0;
    endfunction

    function asw_pkg::val_t clamp(longint v);
      if (v > 524287) return asw_pkg::VAL_MAX;
      if (v < -524288) return asw_pkg::VAL_MIN;
      return asw_pkg::val_t'(v);
    endfunction

    function void write_reg(logic [asw_pkg::CFG_IDX_W-1:0] idx,
                            logic [asw_pkg::CFG_W-1:0] data);
      case (idx)
        asw_pkg::REG_ZERO_OFFSET:      zero_offset      = data[asw_pkg::RAW_W-1:0];
        asw_pkg::REG_COUNT_GAIN:       count_gain       = data[asw_pkg::GAIN_W-1:0];
        asw_pkg::REG_SMOOTHING_FACTOR: smoothing_factor = data[asw_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [asw_pkg::RAW_W-1:0] raw);
      longint        d;
      longint        weight;
      longint        step;
      asw_pkg::val_t accel;
      asw_pkg::val_t next;
      accel_result_t res;
      d      = longint'(raw) - longint'(zero_offset);
      accel  = clamp((d * longint'(count_gain) + 32768) >>> 16);
      weight = (smoothing_factor > asw_pkg::ONE_Q16) ? 65536 : longint'(smoothing_factor);
      step   = (weight * (longint'(accel) - longint'(smoothed_now)) + 32768) >>> 16;
      next   = clamp(longint'(smoothed_now) + step);
      smoothed_now = next;
      window_total = window_total - longint'(window[slot]) + longint'(next);
      window[slot] = next;
      slot = (slot + 1) % WIN;
      res.smoothed = next;
      res.mean     = clamp(window_total >>> $clog2(WIN));
      awaited_accel.push_back(res);
    endfunction

    function void check_result(asw_pkg::val_t smoothed, asw_pkg::val_t mean);
      accel_result_t exp_res;
      if (awaited_accel.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got smoothed %0d average %0d",
                 $time, smoothed, mean);
        failures++;
        return;
      end
      exp_res = awaited_accel.pop_front();
      if (smoothed !== exp_res.smoothed) begin
        $display("%0t smoothed_accel mismatch: expected %0d, got %0d",
                 $time, exp_res.smoothed, smoothed);
        failures++;
      end
      if (mean !== exp_res.mean) begin
        $display("%0t average_accel mismatch: expected %0d, got %0d",
                 $time, exp_res.mean, mean);
        failures++;
      end
    endfunction
  endclass

  // dut connections, all inputs known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [asw_pkg::RAW_W-1:0] raw_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [asw_pkg::VAL_W-1:0] smoothed_accel;
  logic signed [asw_pkg::VAL_W-1:0] average_accel;
  logic cfg_wr_en = 1'b0;
  logic [asw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [asw_pkg::CFG_W-1:0] cfg_data = '0;

  window_average_scoreboard sb;

  // idle percentages for the current phase
  int send_idle_pct = 7;
  int recv_idle_pct = 46;

  // samples waiting to be driven, and the random-walk level they wander around
  logic signed [asw_pkg::RAW_W-1:0] sample_q[$];
  int walk_level = 0;
  int cycle_count = 0;

  accel_smoothing_window_average_top #(
    .WINDOW_LENGTH(WIN)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_sample    (raw_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .smoothed_accel(smoothed_accel),
    .average_accel (average_accel),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // result side: check each accepted beat, then choose next cycle's stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(smoothed_accel, average_accel);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog, well above the slowest legal run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one register write per edge; enable stays high for back-to-back writes
  task automatic write_reg(logic [asw_pkg::CFG_IDX_W-1:0] idx,
                           logic [asw_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_done();
    cfg_wr_en <= 1'b0;
  endtask

  // drive every queued sample, with random gaps between beats
  task automatic play_samples();
    logic signed [asw_pkg::RAW_W-1:0] raw;
    while (sample_q.size() != 0) begin
      raw = sample_q.pop_front();
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
      end
      in_valid   <= 1'b1;
      raw_sample <= raw;
      @(posedge clk);
      // payload held while stalled
      while (in_stall) @(posedge clk);
      sb.note_sample(raw);
    end
    in_valid <= 1'b0;
  endtask

  // block is idle once every result beat has come back
  task automatic wait_drained();
    while (sb.awaited_accel.size() != 0) @(posedge clk);
  endtask

  // mostly slow wandering signal, some full-range noise, some rail values
  function automatic logic signed [asw_pkg::RAW_W-1:0] next_raw();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 49) == 0) walk_level = $signed(16'($urandom));
      walk_level = walk_level + $urandom_range(0, 512) - 256;
      if (walk_level > 32767) walk_level = 32767;
      if (walk_level < -32768) walk_level = -32768;
      return 16'(walk_level);
    end else if (pick < 85) begin
      return 16'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
  endfunction

  // random register setting for one block of traffic, extremes weighted in
  task automatic random_config();
    logic [asw_pkg::CFG_W-1:0] data;
    data = 24'($urandom);
    case ($urandom_range(0, 3))
      0: data[15:0] = 16'h8000;
      1: data[15:0] = 16'h7fff;
      2: data[15:0] = 16'h0000;
      default: data[15:0] = 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
    write_reg(asw_pkg::REG_ZERO_OFFSET, data);
    case ($urandom_range(0, 4))
      0: data = 24'd0;
      1: data = 24'hffffff;
      2: data = asw_pkg::GAIN_RESET;
      3: data = 24'($urandom_range(0, 2097152));
      default: data = 24'($urandom);
    endcase
    write_reg(asw_pkg::REG_COUNT_GAIN, data);
    data = 24'($urandom);
    case ($urandom_range(0, 4))
      0: data[16:0] = 17'd0;
      1: data[16:0] = asw_pkg::ONE_Q16;
      2: data[16:0] = 17'($urandom_range(65537, 131071));
      3: data[16:0] = 17'($urandom_range(1, 65535));
      default: data[16:0] = 17'($urandom_range(1, 8000));
    endcase
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 24'($urandom));
    cfg_done();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, window ramping up from empty
    sample_q = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
    play_samples();
    wait_drained();

    // unused index ignored; top gain with full weight overflows upwards
    write_reg(REG_UNUSED, 24'($urandom));
    write_reg(asw_pkg::REG_ZERO_OFFSET, {8'hff, 16'h8000});
    write_reg(asw_pkg::REG_COUNT_GAIN, 24'hffffff);
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, {7'h7f, asw_pkg::ONE_Q16});
    cfg_done();
    sample_q = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd100};
    play_samples();
    wait_drained();

    // weight above one acts as one; negative overflow
    write_reg(asw_pkg::REG_ZERO_OFFSET, {8'h00, 16'h7fff});
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, 24'h01ffff);
    cfg_done();
    sample_q = '{-16'sd32768, 16'sd0, 16'sd32767};
    play_samples();
    wait_drained();

    // zero weight holds the smoothed value
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, 24'd0);
    cfg_done();
    sample_q = '{-16'sd32768, 16'sd12345, 16'sd32767};
    play_samples();
    wait_drained();

    // zero gain pulls everything to zero
    write_reg(asw_pkg::REG_ZERO_OFFSET, 24'd0);
    write_reg(asw_pkg::REG_COUNT_GAIN, 24'd0);
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, {7'd0, asw_pkg::ONE_Q16});
    cfg_done();
    sample_q = '{16'sd5000, -16'sd5000};
    play_samples();
    wait_drained();

    // smallest gain and weight, rounding steps
    write_reg(asw_pkg::REG_COUNT_GAIN, 24'd1);
    write_reg(asw_pkg::REG_SMOOTHING_FACTOR, 24'd1);
    cfg_done();
    sample_q = '{16'sd32767, 16'sd32767, -16'sd32768};
    play_samples();

    // random traffic: three idle phases, three register settings in each
    for (int blk = 0; blk < BLOCKS; blk++) begin
      wait_drained();
      case (blk / 3)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_config();
      for (int n = 0; n < BLOCK_ITEMS; n++) sample_q.push_back(next_raw());
      play_samples();
    end

    // let the last beats come back, then look for stray ones
    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
